>>> sv/btcs_pkg.sv
// Shared types, constants and helpers for the blink time-code sequencer.
package btcs_pkg;

    localparam int TIME_W       = 32;
    localparam int HALF_W       = 16;
    localparam int GAP_W        = 16;
    localparam int IDLE_W       = 20;
    localparam int STATUS_W     = 10;
    localparam int COUNT_W      = 5;
    localparam int COLOR_W      = 8;
    localparam int PHASE_CODE_W = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 20;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 32;

    localparam logic [HALF_W-1:0]   HALF_PERIOD_RESET  = 16'd500;
    localparam logic [GAP_W-1:0]    GAP_RESET          = 16'd1000;
    localparam logic [IDLE_W-1:0]   IDLE_WAIT_RESET    = 20'd3000;
    localparam logic [STATUS_W-1:0] STATUS_ON_RESET    = 10'd200;
    localparam logic [STATUS_W-1:0] STATUS_PERIOD_LAST = 10'd999;

    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
    localparam logic [COLOR_W-1:0] COLOR_NONE = 8'd0;

    // Link status selector codes
    localparam logic [7:0] LINK_BLUE       = 8'd1;
    localparam logic [7:0] LINK_MAGENTA    = 8'd2;
    localparam logic [7:0] LINK_GREEN_SLOT = 8'd3;

    // Phase codes as reported on the result
    localparam logic [PHASE_CODE_W-1:0] PH_CODE_IDLE    = 3'd0;
    localparam logic [PHASE_CODE_W-1:0] PH_CODE_HOUR    = 3'd1;
    localparam logic [PHASE_CODE_W-1:0] PH_CODE_PAUSE1  = 3'd2;
    localparam logic [PHASE_CODE_W-1:0] PH_CODE_QUARTER = 3'd3;
    localparam logic [PHASE_CODE_W-1:0] PH_CODE_PAUSE2  = 3'd4;
    localparam logic [PHASE_CODE_W-1:0] PH_CODE_MINUTE  = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HALF_PERIOD = 2'd0,
        REG_GAP         = 2'd1,
        REG_IDLE_WAIT   = 2'd2,
        REG_STATUS_ON   = 2'd3
    } cfg_reg_t;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_HOUR    = 6'b000010,
        PH_PAUSE1  = 6'b000100,
        PH_QUARTER = 6'b001000,
        PH_PAUSE2  = 6'b010000,
        PH_MINUTE  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [HALF_W-1:0]   half_period;
        logic [GAP_W-1:0]    gap;
        logic [IDLE_W-1:0]   idle_wait;
        logic [STATUS_W-1:0] status_on;
    } cfg_t;

    typedef struct packed {
        logic         synced;
        logic [7:0]   link_status;
        logic [4:0]   hour_count;
        logic [1:0]   quarter_count;
        logic [3:0]   minute_remainder;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic                    led_write;
        color_t                  color;
        logic [PHASE_CODE_W-1:0] phase_now;
    } result_t;

    localparam color_t COLOR_OFF     = '{COLOR_NONE, COLOR_NONE, COLOR_NONE};
    localparam color_t COLOR_HOUR    = '{COLOR_NONE, COLOR_FULL, COLOR_NONE};
    localparam color_t COLOR_QUARTER = '{COLOR_FULL, COLOR_NONE, COLOR_NONE};
    localparam color_t COLOR_MINUTE  = '{COLOR_NONE, COLOR_NONE, COLOR_FULL};

    function automatic color_t status_color(input logic [7:0] link);
        color_t c;
        priority case (link)
            LINK_BLUE:       c = '{COLOR_NONE, COLOR_NONE, COLOR_FULL};
            LINK_MAGENTA:    c = '{COLOR_FULL, COLOR_NONE, COLOR_FULL};
            LINK_GREEN_SLOT: c = '{COLOR_NONE, COLOR_FULL, COLOR_NONE};
            default:         c = '{COLOR_FULL, COLOR_NONE, COLOR_NONE};
        endcase
        return c;
    endfunction

    function automatic logic [PHASE_CODE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_CODE_W-1:0] code;
        unique case (ph)
            PH_HOUR:    code = PH_CODE_HOUR;
            PH_PAUSE1:  code = PH_CODE_PAUSE1;
            PH_QUARTER: code = PH_CODE_QUARTER;
            PH_PAUSE2:  code = PH_CODE_PAUSE2;
            PH_MINUTE:  code = PH_CODE_MINUTE;
            default:    code = PH_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> sv/btcs_seq.sv
// Sequencer state and the per-tick update for the blink time-code sequencer.
module btcs_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  btcs_pkg::in_item_t item,
    input  btcs_pkg::cfg_t    cfg,
    output btcs_pkg::result_t result
);
    import btcs_pkg::*;

    logic [TIME_W-1:0]   tick_time_reg, tick_time_next;
    logic [STATUS_W-1:0] status_phase_reg, status_phase_next;
    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  blinks_done_reg, blinks_done_next;
    logic [COUNT_W-1:0]  blinks_wanted_reg, blinks_wanted_next;
    logic                lamp_lit_reg, lamp_lit_next;
    logic [TIME_W-1:0]   last_toggle_reg, last_toggle_next;
    logic [TIME_W-1:0]   pause_start_reg, pause_start_next;
    logic [TIME_W-1:0]   display_start_reg, display_start_next;

    logic [TIME_W-1:0]   timer_base;
    logic [TIME_W-1:0]   timer_limit;
    logic [TIME_W-1:0]   elapsed;
    logic                timer_done;
    color_t              blink_color;
    phase_t              after_blink;
    logic [COUNT_W-1:0]  pause_count;
    logic                led_write;
    color_t              led_color;

    // One shared elapsed-time compare; the phase picks its start mark and limit
    always_comb begin
        blink_color = COLOR_HOUR;
        after_blink = PH_PAUSE1;
        pause_count = {{(COUNT_W-2){1'b0}}, item.quarter_count};
        unique case (phase_reg)
            PH_HOUR: begin
                timer_base  = last_toggle_reg;
                timer_limit = {{(TIME_W-HALF_W){1'b0}}, cfg.half_period};
            end
            PH_QUARTER: begin
                timer_base  = last_toggle_reg;
                timer_limit = {{(TIME_W-HALF_W){1'b0}}, cfg.half_period};
                blink_color = COLOR_QUARTER;
                after_blink = PH_PAUSE2;
            end
            PH_MINUTE: begin
                timer_base  = last_toggle_reg;
                timer_limit = {{(TIME_W-HALF_W){1'b0}}, cfg.half_period};
                blink_color = COLOR_MINUTE;
                after_blink = PH_IDLE;
            end
            PH_PAUSE1: begin
                timer_base  = pause_start_reg;
                timer_limit = {{(TIME_W-GAP_W){1'b0}}, cfg.gap};
            end
            PH_PAUSE2: begin
                timer_base  = pause_start_reg;
                timer_limit = {{(TIME_W-GAP_W){1'b0}}, cfg.gap};
                pause_count = {1'b0, item.minute_remainder};
            end
            default: begin
                timer_base  = display_start_reg;
                timer_limit = {{(TIME_W-IDLE_W){1'b0}}, cfg.idle_wait};
            end
        endcase
        elapsed    = tick_time_reg - timer_base;
        timer_done = (elapsed >= timer_limit);
    end

    always_comb begin
        tick_time_next     = tick_time_reg + {{(TIME_W-1){1'b0}}, 1'b1};
        status_phase_next  = (status_phase_reg >= STATUS_PERIOD_LAST) ? '0
                           : status_phase_reg + {{(STATUS_W-1){1'b0}}, 1'b1};
        phase_next         = phase_reg;
        blinks_done_next   = blinks_done_reg;
        blinks_wanted_next = blinks_wanted_reg;
        lamp_lit_next      = lamp_lit_reg;
        last_toggle_next   = last_toggle_reg;
        pause_start_next   = pause_start_reg;
        display_start_next = display_start_reg;
        led_write          = 1'b0;
        led_color          = COLOR_OFF;

        if (!item.synced) begin
            // Status flash; sequence holds
            led_write = 1'b1;
            if (status_phase_reg < cfg.status_on) begin
                led_color = status_color(item.link_status);
            end
        end else begin
            unique case (phase_reg)
                PH_HOUR, PH_QUARTER, PH_MINUTE: begin
                    if (timer_done) begin
                        last_toggle_next = tick_time_reg;
                        lamp_lit_next    = !lamp_lit_reg;
                        led_write        = 1'b1;
                        if (!lamp_lit_reg) begin
                            blinks_done_next = blinks_done_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                            led_color        = blink_color;
                        end else if (blinks_done_reg >= blinks_wanted_reg) begin
                            pause_start_next = tick_time_reg;
                            phase_next       = after_blink;
                        end
                    end
                end
                PH_PAUSE1, PH_PAUSE2: begin
                    if (timer_done) begin
                        blinks_done_next   = '0;
                        blinks_wanted_next = pause_count;
                        lamp_lit_next      = 1'b0;
                        last_toggle_next   = tick_time_reg;
                        if (pause_count == '0) begin
                            // Skip an empty count
                            if (phase_reg == PH_PAUSE1) begin
                                phase_next       = PH_PAUSE2;
                                pause_start_next = tick_time_reg;
                            end else begin
                                phase_next         = PH_IDLE;
                                display_start_next = tick_time_reg;
                            end
                        end else begin
                            phase_next = (phase_reg == PH_PAUSE1) ? PH_QUARTER : PH_MINUTE;
                        end
                    end else begin
                        led_write = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    if (timer_done) begin
                        blinks_done_next   = '0;
                        blinks_wanted_next = item.hour_count;
                        lamp_lit_next      = 1'b0;
                        last_toggle_next   = tick_time_reg;
                        phase_next         = PH_HOUR;
                        display_start_next = tick_time_reg;
                    end
                end
            endcase
        end

        result.led_write = led_write;
        result.color     = led_color;
        result.phase_now = phase_code(phase_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_time_reg     <= '0;
            status_phase_reg  <= '0;
            phase_reg         <= PH_IDLE;
            blinks_done_reg   <= '0;
            blinks_wanted_reg <= '0;
            lamp_lit_reg      <= 1'b0;
            last_toggle_reg   <= '0;
            pause_start_reg   <= '0;
            display_start_reg <= '0;
        end else if (step) begin
            tick_time_reg     <= tick_time_next;
            status_phase_reg  <= status_phase_next;
            phase_reg         <= phase_next;
            blinks_done_reg   <= blinks_done_next;
            blinks_wanted_reg <= blinks_wanted_next;
            lamp_lit_reg      <= lamp_lit_next;
            last_toggle_reg   <= last_toggle_next;
            pause_start_reg   <= pause_start_next;
            display_start_reg <= display_start_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.synced && phase_reg == PH_IDLE |-> !result.led_write)
        else $error("LED write issued from idle");

    a_pause_end_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.synced && timer_done
            && (phase_reg == PH_PAUSE1 || phase_reg == PH_PAUSE2) |-> !result.led_write)
        else $error("LED write on the tick that ends a pause");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status_phase_reg <= STATUS_PERIOD_LAST)
        else $error("status phase out of range");

    a_frozen_unsynced: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !item.synced |=> phase_reg == $past(phase_reg))
        else $error("sequence moved while not synced");
`endif

endmodule

>>> sv/blink_time_code_sequencer.sv
// Top level of the blink time-code sequencer: stream ports, config registers, pipeline.
//
// Each input word is one 1 ms tick and yields exactly one result word. The block takes
// one word per clock while the output is not stalled: a word sits in the input
// register while the sequencer updates its state in a single pass (one shared 32-bit
// elapsed-time subtract and compare), then lands in the result register.
// While a finished result waits on m_tready, s_tready stays high until one more word
// is held in the input register behind it, then drops until m_tready returns.
// Configuration writes are taken at any time (cfg_ready is always high) and must only
// be issued while no tick is in flight.
module blink_time_code_sequencer (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // synced[0], link_status[8:1], hour_count[13:9], quarter_count[15:14],
    // minute_remainder[19:16], zero fill [23:20]
    input  logic [btcs_pkg::S_TDATA_W-1:0]         s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // led_write[0], led_green[8:1], led_red[16:9], led_blue[24:17],
    // phase_now[27:25], zero fill [31:28]
    output logic [btcs_pkg::M_TDATA_W-1:0]         m_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [btcs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [btcs_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import btcs_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  out_result_reg;
    result_t  seq_result;
    logic     advance;
    logic     s_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HALF_PERIOD: cfg_next.half_period = cfg_data[HALF_W-1:0];
                REG_GAP:         cfg_next.gap         = cfg_data[GAP_W-1:0];
                REG_IDLE_WAIT:   cfg_next.idle_wait   = cfg_data[IDLE_W-1:0];
                REG_STATUS_ON:   cfg_next.status_on   = cfg_data[STATUS_W-1:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period <= HALF_PERIOD_RESET;
            cfg_reg.gap         <= GAP_RESET;
            cfg_reg.idle_wait   <= IDLE_WAIT_RESET;
            cfg_reg.status_on   <= STATUS_ON_RESET;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the input loads on accept, the result on advance; both hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.synced           <= s_tdata[0];
            in_item_reg.link_status      <= s_tdata[8:1];
            in_item_reg.hour_count       <= s_tdata[13:9];
            in_item_reg.quarter_count    <= s_tdata[15:14];
            in_item_reg.minute_remainder <= s_tdata[19:16];
        end
        if (advance) begin
            out_result_reg <= seq_result;
        end
    end

    btcs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (seq_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-28){1'b0}},
                       out_result_reg.phase_now,
                       out_result_reg.color.blue,
                       out_result_reg.color.red,
                       out_result_reg.color.green,
                       out_result_reg.led_write};

`ifndef SYNTHESIS
    a_off_when_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_result_reg.led_write |-> out_result_reg.color == COLOR_OFF)
        else $error("color present without an LED write");

    a_word_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("pending tick lost while output stalled");

    a_phase_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_result_reg.phase_now <= PH_CODE_MINUTE)
        else $error("phase code out of range");
`endif

endmodule
